>>> design/csm_pkg.sv
// Shared types and codes for the counter statistics monitor.
// Holds the input beat and result beat structs, opcode and direction codes.
// No dependencies.
package csm_pkg;

  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned TOTAL_BITS = 32;
  localparam int unsigned WIDTH_BITS = 7;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    DIR_CONSTANT = 2'd0,
    DIR_UP       = 2'd1,
    DIR_DOWN     = 2'd2,
    DIR_MIXED    = 2'd3
  } direction_t;

  typedef struct packed {
    opcode_t                 opcode;
    logic [VALUE_BITS-1:0]   sample_value;
    logic                    sample_unknown;
  } sample_item_t;

  typedef struct packed {
    logic                    sample_accepted;
    logic [TOTAL_BITS-1:0]   sample_total;
    logic [VALUE_BITS-1:0]   low_value;
    logic [VALUE_BITS-1:0]   high_value;
    logic [TOTAL_BITS-1:0]   rise_total;
    logic [TOTAL_BITS-1:0]   fall_total;
    logic [TOTAL_BITS-1:0]   wrap_total;
    direction_t              direction;
  } result_item_t;

endpackage

>>> design/csm_stats.sv
// Statistics state and the single-pass update for one beat.
// Depends on csm_pkg for the beat structs and codes.
module csm_stats import csm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  sample_item_t          item,
  input  logic [VALUE_BITS-1:0] scale_mask,
  output result_item_t          result
);

  logic [COUNT_BITS-1:0] seen_count, seen_count_next;
  logic [COUNT_BITS-1:0] rises, rises_next;
  logic [COUNT_BITS-1:0] falls, falls_next;
  logic [COUNT_BITS-1:0] wraps, wraps_next;
  logic [VALUE_BITS-1:0] lowest_seen, lowest_seen_next;
  logic [VALUE_BITS-1:0] highest_seen, highest_seen_next;
  logic [VALUE_BITS-1:0] previous_sample, previous_sample_next;
  logic                  have_previous, have_previous_next;

  logic                  is_clear;
  logic                  take;
  logic [VALUE_BITS-1:0] cur;
  logic [VALUE_BITS-1:0] half;
  logic                  is_rise;
  logic                  is_fall;
  logic                  is_wrap;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic [TOTAL_BITS-1:0] to_total(input logic [COUNT_BITS-1:0] c);
    logic [VALUE_BITS-1:0] wide;
    wide = VALUE_BITS'(c);
    return wide[TOTAL_BITS-1:0];
  endfunction

  always_comb begin
    is_clear = (item.opcode == OP_CLEAR);
    take     = !is_clear && !item.sample_unknown;
    cur      = item.sample_value & scale_mask;
    half     = scale_mask >> 1;
    is_rise  = have_previous && (cur > previous_sample);
    is_fall  = have_previous && (cur < previous_sample);
    is_wrap  = is_fall && (previous_sample > half) && (cur < half);

    seen_count_next      = seen_count;
    rises_next           = rises;
    falls_next           = falls;
    wraps_next           = wraps;
    lowest_seen_next     = lowest_seen;
    highest_seen_next    = highest_seen;
    previous_sample_next = previous_sample;
    have_previous_next   = have_previous;

    if (is_clear) begin
      seen_count_next      = '0;
      rises_next           = '0;
      falls_next           = '0;
      wraps_next           = '0;
      lowest_seen_next     = '1;
      highest_seen_next    = '0;
      previous_sample_next = '0;
      have_previous_next   = 1'b0;
    end else if (take) begin
      seen_count_next = sat_inc(seen_count);
      if (cur < lowest_seen) begin
        lowest_seen_next = cur;
      end
      if (cur > highest_seen) begin
        highest_seen_next = cur;
      end
      if (is_rise) begin
        rises_next = sat_inc(rises);
      end
      if (is_fall) begin
        falls_next = sat_inc(falls);
      end
      if (is_wrap) begin
        wraps_next = sat_inc(wraps);
      end
      previous_sample_next = cur;
      have_previous_next   = 1'b1;
    end

    result.sample_accepted = take;
    result.sample_total    = to_total(seen_count_next);
    result.low_value       = have_previous_next ? lowest_seen_next : '0;
    result.high_value      = have_previous_next ? highest_seen_next : '0;
    result.rise_total      = to_total(rises_next);
    result.fall_total      = to_total(falls_next);
    result.wrap_total      = to_total(wraps_next);

    if ((|rises_next) && !(|falls_next)) begin
      result.direction = DIR_UP;
    end else if ((|falls_next) && !(|rises_next)) begin
      result.direction = DIR_DOWN;
    end else if ((|rises_next) || (|falls_next)) begin
      result.direction = DIR_MIXED;
    end else begin
      result.direction = DIR_CONSTANT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count      <= '0;
      rises           <= '0;
      falls           <= '0;
      wraps           <= '0;
      lowest_seen     <= '1;
      highest_seen    <= '0;
      previous_sample <= '0;
      have_previous   <= 1'b0;
    end else if (advance) begin
      seen_count      <= seen_count_next;
      rises           <= rises_next;
      falls           <= falls_next;
      wraps           <= wraps_next;
      lowest_seen     <= lowest_seen_next;
      highest_seen    <= highest_seen_next;
      previous_sample <= previous_sample_next;
      have_previous   <= have_previous_next;
    end
  end

endmodule

>>> design/counter_statistics_monitor_top.sv
// Top level of the counter statistics monitor: input register, width register,
// statistics core and result register. Depends on csm_pkg and csm_stats.
//
//   channel   | handshake                     | payload
//   ----------+-------------------------------+----------------------------
//   sample    | sample_valid / sample_stall   | sample_data  (sample_item_t)
//   result    | result_valid / result_stall   | result_data  (result_item_t)
//   config    | cfg_wr_en                     | cfg_wr_data  (7 bits)
//
// One beat per cycle sustained while result_stall is low; a beat lands in the
// input register when accepted and reaches result_data via the result register.
// The statistics update sits in one combinational pass between the two registers.
// Synchronous reset clears the statistics and sets the watched width to 64.
// A stall on a valid result holds the result register and the input register;
// with a beat waiting in the input register sample_stall rises in that same
// cycle. Nothing is dropped.
module counter_statistics_monitor_top import csm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_item_t          sample_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_item_t          result_data,
  input  logic                  cfg_wr_en,
  input  logic [WIDTH_BITS-1:0] cfg_wr_data
);

  logic                  hold_valid;
  sample_item_t          hold_item;
  logic [VALUE_BITS-1:0] scale_mask;
  logic [VALUE_BITS-1:0] scale_mask_next;
  logic [WIDTH_BITS-1:0] width_eff;
  logic                  advance;
  logic                  accept;
  result_item_t          stats_result;

  assign advance      = hold_valid && (!result_valid || !result_stall);
  assign sample_stall = hold_valid && !advance;
  assign accept       = sample_valid && !sample_stall;

  // Clamp the written width to 1..64 and turn it into a full-scale mask.
  always_comb begin
    if (cfg_wr_data == '0) begin
      width_eff = WIDTH_BITS'(1);
    end else if (cfg_wr_data >= WIDTH_BITS'(VALUE_BITS)) begin
      width_eff = WIDTH_BITS'(VALUE_BITS);
    end else begin
      width_eff = cfg_wr_data;
    end
    if (width_eff == WIDTH_BITS'(VALUE_BITS)) begin
      scale_mask_next = '1;
    end else begin
      scale_mask_next = ~({VALUE_BITS{1'b1}} << width_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mask <= '1;
    end else if (cfg_wr_en) begin
      scale_mask <= scale_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item <= sample_data;
    end
  end

  csm_stats #(
    .COUNT_BITS(COUNT_BITS)
  ) u_stats (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (hold_item),
    .scale_mask (scale_mask),
    .result     (stats_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_data <= stats_result;
    end
  end

endmodule
